FILE: sv/hmd_pkg.sv
// ----------------------------------------------------------------------------
// hmd_pkg
// Shared types and defaults for the homogeneous monomial derivative block:
// derivative phases and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package hmd_pkg;

    // default configuration of the block
    localparam int MAX_DEGREE_DEF = 31;
    localparam int COEF_BITS_DEF  = 32;

    // fixed field widths
    localparam int EXP_W     = 5;
    localparam int COEF_W    = 32;
    localparam int IN_DATA_W = 72;   // coef + 8 exponent/order fields
    localparam int OUT_DATA_W = 48;  // coef + 3 exponents, padded to bytes
    localparam int OUT_USER_W = 2;

    // derivative phases, applied in this order
    typedef enum logic [1:0] {
        PH_W = 2'd0,
        PH_X = 2'd1,
        PH_Y = 2'd2,
        PH_Z = 2'd3
    } t_phase;

    // commands from the controller to the datapath
    typedef struct packed {
        logic   load;      // capture input item
        logic   arm;       // load factor register with current exponent
        logic   step;      // multiply coefficient by factor, decrement factor
        logic   kill;      // mark result as zero monomial
        logic   lower;     // lower x, y or z exponent of current phase by its order
        logic   out_load;  // capture result into output register
        t_phase phase;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic             skip;   // order of current phase is not positive
        logic             kill;   // order exceeds exponent
        logic             zero;   // result already annihilated
        logic [EXP_W-1:0] n;      // order of current phase
    } t_stat;

endpackage

FILE: sv/hmd_dp.sv
// ----------------------------------------------------------------------------
// hmd_dp
// Datapath: input capture, per-phase order/exponent checks, shared
// coefficient-by-factor multiplier with saturation, output register.
// ----------------------------------------------------------------------------
module hmd_dp #(
    parameter int COEF_BITS = hmd_pkg::COEF_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic [hmd_pkg::IN_DATA_W-1:0]   i_data,
    input  hmd_pkg::t_cmd                   i_cmd,
    output hmd_pkg::t_stat                  o_stat,
    output logic [hmd_pkg::OUT_DATA_W-1:0]  o_data,
    output logic [hmd_pkg::OUT_USER_W-1:0]  o_user
);

    localparam int EW = hmd_pkg::EXP_W;
    localparam int CW = hmd_pkg::COEF_W;
    localparam int PW = COEF_BITS + EW;

    // working registers
    logic [COEF_BITS-1:0] r_mag;
    logic [COEF_BITS-1:0] r_lim;
    logic                 r_neg;
    logic                 r_sat;
    logic                 r_zero;
    logic [EW-1:0]        r_ex, r_ey, r_ez, r_md;
    logic [EW-1:0]        r_ox, r_oy, r_oz, r_od;
    logic [EW-1:0]        r_top;

    // output registers
    logic [CW-1:0]        r_out_coef;
    logic [EW-1:0]        r_out_x, r_out_y, r_out_z;
    logic                 r_out_zero;
    logic                 r_out_sat;

    // input unpacking, coefficient taken to COEF_BITS
    logic [COEF_BITS+CW-1:0] in_ext;
    logic [COEF_BITS-1:0]    in_raw;
    logic [COEF_BITS-1:0]    in_neg_mag;
    logic                    in_neg;
    logic [COEF_BITS-1:0]    sign_bit;

    assign in_ext     = {{COEF_BITS{1'b0}}, i_data[CW-1:0]};
    assign in_raw     = in_ext[COEF_BITS-1:0];
    assign in_neg     = in_raw[COEF_BITS-1];
    assign in_neg_mag = ~in_raw + 1'b1;
    assign sign_bit   = {1'b1, {(COEF_BITS-1){1'b0}}};

    // signed w order and implied w exponent
    logic signed [7:0] ow;
    logic signed [7:0] kw;

    assign ow = 8'(r_od) - 8'(r_ox) - 8'(r_oy) - 8'(r_oz);
    assign kw = 8'(r_md) - 8'(r_ex) - 8'(r_ey) - 8'(r_ez);

    // per-phase order and exponent selection
    logic [EW-1:0] sel_n;
    logic [EW-1:0] sel_e;
    logic          sel_skip;
    logic          sel_kill;

    always_comb begin
        sel_n    = '0;
        sel_e    = '0;
        sel_skip = 1'b1;
        sel_kill = 1'b0;
        case (i_cmd.phase)
            hmd_pkg::PH_W: begin
                sel_n    = ow[EW-1:0];
                sel_e    = kw[EW-1:0];
                sel_skip = (ow <= 8'sd0);
                sel_kill = (kw <= 8'sd0) || (kw < ow);
            end
            hmd_pkg::PH_X: begin
                sel_n    = r_ox;
                sel_e    = r_ex;
                sel_skip = (r_ox == '0);
                sel_kill = (r_ox > r_ex);
            end
            hmd_pkg::PH_Y: begin
                sel_n    = r_oy;
                sel_e    = r_ey;
                sel_skip = (r_oy == '0);
                sel_kill = (r_oy > r_ey);
            end
            hmd_pkg::PH_Z: begin
                sel_n    = r_oz;
                sel_e    = r_ez;
                sel_skip = (r_oz == '0);
                sel_kill = (r_oz > r_ez);
            end
            default: begin
                sel_skip = 1'b1;
            end
        endcase
    end

    assign o_stat.skip = sel_skip;
    assign o_stat.kill = sel_kill;
    assign o_stat.zero = r_zero;
    assign o_stat.n    = sel_n;

    // shared multiplier with saturation against the sign-dependent limit
    logic [PW-1:0] prod;
    logic          prod_over;

    assign prod      = PW'(r_mag) * PW'(r_top);
    assign prod_over = prod > PW'(r_lim);

    // signed result and its low 32 bits
    logic [COEF_BITS-1:0]    res;
    logic [COEF_BITS+CW-1:0] res_ext;

    assign res     = r_neg ? (~r_mag + 1'b1) : r_mag;
    assign res_ext = {{CW{1'b0}}, res};

    // working register updates
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg  <= in_neg;
            r_mag  <= in_neg ? in_neg_mag : in_raw;
            r_lim  <= in_neg ? sign_bit : (sign_bit - 1'b1);
            r_sat  <= 1'b0;
            r_zero <= 1'b0;
            r_ex   <= i_data[CW+1*EW-1 -: EW];
            r_ey   <= i_data[CW+2*EW-1 -: EW];
            r_ez   <= i_data[CW+3*EW-1 -: EW];
            r_md   <= i_data[CW+4*EW-1 -: EW];
            r_ox   <= i_data[CW+5*EW-1 -: EW];
            r_oy   <= i_data[CW+6*EW-1 -: EW];
            r_oz   <= i_data[CW+7*EW-1 -: EW];
            r_od   <= i_data[CW+8*EW-1 -: EW];
        end else begin
            if (i_cmd.kill) begin
                r_zero <= 1'b1;
            end
            if (i_cmd.arm) begin
                r_top <= sel_e;
            end
            if (i_cmd.step) begin
                r_top <= r_top - 1'b1;
                if (prod_over) begin
                    r_mag <= r_lim;
                    r_sat <= 1'b1;
                end else begin
                    r_mag <= prod[COEF_BITS-1:0];
                end
            end
            if (i_cmd.lower) begin
                case (i_cmd.phase)
                    hmd_pkg::PH_X: r_ex <= r_ex - r_ox;
                    hmd_pkg::PH_Y: r_ey <= r_ey - r_oy;
                    hmd_pkg::PH_Z: r_ez <= r_ez - r_oz;
                    default: begin
                    end
                endcase
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_zero) begin
                r_out_coef <= '0;
                r_out_x    <= '0;
                r_out_y    <= '0;
                r_out_z    <= '0;
                r_out_zero <= 1'b1;
                r_out_sat  <= 1'b0;
            end else begin
                r_out_coef <= res_ext[CW-1:0];
                r_out_x    <= r_ex;
                r_out_y    <= r_ey;
                r_out_z    <= r_ez;
                r_out_zero <= 1'b0;
                r_out_sat  <= r_sat;
            end
        end
    end

    assign o_data = {1'b0, r_out_z, r_out_y, r_out_x, r_out_coef};
    assign o_user = {r_out_sat, r_out_zero};

endmodule

FILE: sv/hmd_ctrl.sv
// ----------------------------------------------------------------------------
// hmd_ctrl
// Controller: walks the w, x, y and z phases, counts multiply steps of each
// falling factorial and owns both stream handshakes.
// ----------------------------------------------------------------------------
module hmd_ctrl #(
    parameter int MAX_DEGREE = hmd_pkg::MAX_DEGREE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    input  hmd_pkg::t_stat i_stat,
    output hmd_pkg::t_cmd  o_cmd
);

    localparam int CNT_W = $clog2(MAX_DEGREE + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_RUN,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    hmd_pkg::t_phase    r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;

    // step count of the phase, capped at the longest falling factorial
    logic [CNT_W-1:0]   cnt_load;

    assign cnt_load = (32'(i_stat.n) > 32'(MAX_DEGREE)) ? CNT_W'(MAX_DEGREE)
                                                        : CNT_W'(i_stat.n);

    // output handshake and slot
    logic out_take;
    logic out_free;

    assign out_take = r_out_valid && i_m_tready;
    assign out_free = !r_out_valid || i_m_tready;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_out_valid = out_take ? 1'b0 : r_out_valid;
        o_cmd       = '0;
        o_cmd.phase = r_phase;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_phase    = hmd_pkg::PH_W;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                if (i_stat.zero || i_stat.skip || i_stat.kill) begin
                    o_cmd.kill = !i_stat.zero && !i_stat.skip && i_stat.kill;
                    if (r_phase == hmd_pkg::PH_Z) begin
                        n_state = S_DONE;
                    end else begin
                        n_phase = hmd_pkg::t_phase'(r_phase + 2'd1);
                    end
                end else begin
                    o_cmd.arm = 1'b1;
                    n_cnt     = cnt_load;
                    n_state   = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    o_cmd.lower = 1'b1;
                    if (r_phase == hmd_pkg::PH_Z) begin
                        n_state = S_DONE;
                    end else begin
                        n_phase = hmd_pkg::t_phase'(r_phase + 2'd1);
                        n_state = S_SETUP;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= hmd_pkg::PH_W;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

FILE: sv/homogeneous_monomial_derivative.sv
// ----------------------------------------------------------------------------
// homogeneous_monomial_derivative
// Partial derivative of a homogeneous monomial in x, y, z and implied w by a
// monomial differential operator, Q16.16 coefficient with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   slave stream  : one monomial plus operator per transfer on i_s_tdata
//   master stream : one result per input, data on o_m_tdata, flags on tuser
//   A transfer happens on a rising edge with tvalid and tready both high.
// Timing:
//   one item is processed at a time; o_s_tready is high only while idle
//   after an input transfer the controller sets up each phase in turn and runs
//   its multiply steps: the w, x, y and z orders that are taken,
//   each capped at MAX_DEGREE; zero results stop adding steps
//   the shared coefficient-by-factor multiplier does one factor per cycle
//   o_s_tready goes high again as the result is registered
// Reset:
//   i_rst_n low returns the controller to idle and drops o_m_tvalid
// Stall:
//   a finished result waits in the output register while i_m_tready is low;
//   the next item is then accepted and computed, and waits for the slot
// ----------------------------------------------------------------------------
module homogeneous_monomial_derivative #(
    parameter int MAX_DEGREE = hmd_pkg::MAX_DEGREE_DEF,
    parameter int COEF_BITS  = hmd_pkg::COEF_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // coef_in[31:0], exp_x, exp_y, exp_z, mono_degree, ord_x, ord_y,
    // ord_z, op_degree (5 bits each)
    input  logic [hmd_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // master stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // coef_out[31:0], exp_x_out, exp_y_out, exp_z_out (5 bits each), pad
    output logic [hmd_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // is_zero, saturated
    output logic [hmd_pkg::OUT_USER_W-1:0]  o_m_tuser
);

    hmd_pkg::t_cmd  cmd;
    hmd_pkg::t_stat stat;

    // control
    hmd_ctrl #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    hmd_dp #(
        .COEF_BITS (COEF_BITS)
    ) u_dp (
        .i_clk  (i_clk),
        .i_data (i_s_tdata),
        .i_cmd  (cmd),
        .o_stat (stat),
        .o_data (o_m_tdata),
        .o_user (o_m_tuser)
    );

endmodule

FILE: sv/hmd_check.sv
// ----------------------------------------------------------------------------
// hmd_check
// Port-level checks of the homogeneous monomial derivative block, bound to
// the top level.
// ----------------------------------------------------------------------------
module hmd_check (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [hmd_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input logic [hmd_pkg::OUT_USER_W-1:0]  o_m_tuser
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // one item at a time: an input transfer closes the input side
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while busy");

    // zero monomial carries all-zero fields and no clip flag
    a_zero_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> (o_m_tdata == '0) && !o_m_tuser[1])
        else $error("zero monomial with nonzero fields");

endmodule

bind homogeneous_monomial_derivative hmd_check u_hmd_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

FILE: tb/hmd_checker.sv
// ----------------------------------------------------------------------------
// hmd_checker
// Watches both streams of the homogeneous monomial derivative block. Each
// input transfer is run through a cycle-free derivative calculation, and the
// result waits in a queue. Each output transfer is compared field by field
// with the oldest waiting result.
// ----------------------------------------------------------------------------
module hmd_checker #(
    parameter int MAX_DEGREE = hmd_pkg::MAX_DEGREE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream as seen at the block
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // coef_in[31:0], exp_x, exp_y, exp_z, mono_degree, ord_x, ord_y,
    // ord_z, op_degree (5 bits each)
    input  logic [hmd_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // output stream as seen at the block
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // coef_out[31:0], exp_x_out, exp_y_out, exp_z_out (5 bits each), pad
    input  logic [hmd_pkg::OUT_DATA_W-1:0] i_m_tdata,
    // is_zero, saturated
    input  logic [hmd_pkg::OUT_USER_W-1:0] i_m_tuser,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_taken,
    output int                             o_checked,
    output int                             o_zero_count,
    output int                             o_sat_count
);

    typedef struct packed {
        logic [hmd_pkg::COEF_W-1:0] coef;
        logic [hmd_pkg::EXP_W-1:0]  ex;
        logic [hmd_pkg::EXP_W-1:0]  ey;
        logic [hmd_pkg::EXP_W-1:0]  ez;
        logic                       is_zero;
        logic                       saturated;
    } t_deriv_res;

    t_deriv_res deriv_q[$];
    int         fails;
    int         taken;
    int         checked;
    int         zeros;
    int         clips;

    assign o_fail_count = fails;
    assign o_pending    = taken - checked;
    assign o_taken      = taken;
    assign o_checked    = checked;
    assign o_zero_count = zeros;
    assign o_sat_count  = clips;

    // multiply magnitude by top*(top-1)*..., clipping at the limit
    function automatic void apply_falling(inout longint unsigned mag, inout bit sat,
                                          input longint unsigned lim, input int top,
                                          input int n);
        longint unsigned f;
        for (int i = 0; i < n && i < MAX_DEGREE; i++) begin
            f = longint'(top - i);
            if (f == 0) begin
                mag = 0;
            end else if (mag > lim / f) begin
                mag = lim;
                sat = 1'b1;
            end else begin
                mag = mag * f;
            end
        end
    endfunction

    // one of the x, y, z derivatives; an order above the exponent kills the term
    function automatic void lower_exp(inout int e, input int n, inout bit dead,
                                      inout longint unsigned mag, inout bit sat,
                                      input longint unsigned lim);
        if (dead || n <= 0)
            return;
        if (e == 0 || n > e) begin
            dead = 1'b1;
            return;
        end
        apply_falling(mag, sat, lim, e, n);
        e = e - n;
    endfunction

    // derivative of one monomial by one operator
    function automatic t_deriv_res derive(input logic [hmd_pkg::IN_DATA_W-1:0] d);
        logic [hmd_pkg::COEF_W-1:0] raw;
        logic [hmd_pkg::COEF_W-1:0] absval;
        int                         ex, ey, ez, md, ox, oy, oz, od, ow, kw;
        bit                         neg;
        bit                         sat;
        bit                         dead;
        longint unsigned            mag;
        longint unsigned            lim;
        t_deriv_res                 r;
        raw    = d[31:0];
        ex     = d[36:32];
        ey     = d[41:37];
        ez     = d[46:42];
        md     = d[51:47];
        ox     = d[56:52];
        oy     = d[61:57];
        oz     = d[66:62];
        od     = d[71:67];
        ow     = od - ox - oy - oz;
        neg    = raw[hmd_pkg::COEF_W-1];
        absval = neg ? (~raw + 1'b1) : raw;
        mag    = absval;
        lim    = neg ? (64'd1 << (hmd_pkg::COEF_W - 1))
                     : ((64'd1 << (hmd_pkg::COEF_W - 1)) - 1);
        sat    = 1'b0;
        dead   = 1'b0;
        // w order comes from the operator degree, w exponent from the monomial degree
        if (ow > 0) begin
            kw = md - ex - ey - ez;
            if (kw <= 0 || kw < ow)
                dead = 1'b1;
            else
                apply_falling(mag, sat, lim, kw, ow);
        end
        lower_exp(ex, ox, dead, mag, sat, lim);
        lower_exp(ey, oy, dead, mag, sat, lim);
        lower_exp(ez, oz, dead, mag, sat, lim);
        r = '0;
        if (dead) begin
            r.is_zero = 1'b1;
        end else begin
            r.coef      = neg ? (~mag[hmd_pkg::COEF_W-1:0] + 1'b1)
                              : mag[hmd_pkg::COEF_W-1:0];
            r.ex        = ex[hmd_pkg::EXP_W-1:0];
            r.ey        = ey[hmd_pkg::EXP_W-1:0];
            r.ez        = ez[hmd_pkg::EXP_W-1:0];
            r.saturated = sat;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fails++;
        end
    endfunction

    // track input transfers and compare output transfers
    always @(posedge i_clk) begin
        t_deriv_res want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                deriv_q.push_back(derive(i_s_tdata));
                taken++;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (deriv_q.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing, actual %h/%b",
                             $time, i_m_tdata, i_m_tuser);
                    fails++;
                end else begin
                    want = deriv_q.pop_front();
                    check_field("coef_out", want.coef, i_m_tdata[31:0]);
                    check_field("exp_x_out", want.ex, i_m_tdata[36:32]);
                    check_field("exp_y_out", want.ey, i_m_tdata[41:37]);
                    check_field("exp_z_out", want.ez, i_m_tdata[46:42]);
                    check_field("is_zero", want.is_zero, i_m_tuser[0]);
                    check_field("saturated", want.saturated, i_m_tuser[1]);
                    checked++;
                    if (want.is_zero)
                        zeros++;
                    if (want.saturated)
                        clips++;
                end
            end
        end
    end

endmodule

FILE: tb/homogeneous_monomial_derivative_tb.sv
// ----------------------------------------------------------------------------
// homogeneous_monomial_derivative_tb
// Drives monomial/operator pairs into the derivative block with random gaps
// and output stalls: a directed set of corner terms first, then mostly
// well-formed random terms mixed with broken and fully random ones. The
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module homogeneous_monomial_derivative_tb;

    localparam int N_RANDOM    = 1080;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 200;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [hmd_pkg::IN_DATA_W-1:0]  i_s_tdata;
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [hmd_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic [hmd_pkg::OUT_USER_W-1:0] o_m_tuser;

    int fail_count;
    int pending;
    int taken;
    int checked;
    int zero_count;
    int sat_count;
    int cycles;
    bit steady;   // both sides run without idling while set

    homogeneous_monomial_derivative u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    hmd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_taken      (taken),
        .o_checked    (checked),
        .o_zero_count (zero_count),
        .o_sat_count  (sat_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle count and run limit
    initial cycles = 0;
    always @(posedge i_clk) cycles <= cycles + 1;

    initial begin
        while (cycles < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
        $display("Mismatches found");
        $finish;
    end

    // output side: random stall after each transfer
    initial begin
        int hold;
        hold       = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready)
                hold = steady ? 0 : $urandom_range(0, 13);
            @(negedge i_clk);
            if (hold > 0) begin
                i_m_tready <= 1'b0;
                hold--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // one input transfer after a random gap
    task automatic send_term(input logic [31:0] coef, input int ex, input int ey,
                             input int ez, input int md, input int ox, input int oy,
                             input int oz, input int od);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 13);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {od[4:0], oz[4:0], oy[4:0], ox[4:0], md[4:0],
                       ez[4:0], ey[4:0], ex[4:0], coef};
        forever begin
            @(posedge i_clk);
            if (o_s_tready)
                break;
        end
    endtask

    // drop the request and hold off until every outstanding result has come back
    task automatic wait_empty();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // mostly small fixed-point values, sometimes any 32-bit pattern
    function automatic logic [31:0] pick_coef();
        logic [31:0] v;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        v = $urandom_range(0, 1 << 18);
        return $urandom_range(0, 1) ? (~v + 1'b1) : v;
    endfunction

    // well-formed term: exponents fit the degree, orders fit the exponents
    task automatic make_valid(output int ex, output int ey, output int ez,
                              output int md, output int ox, output int oy,
                              output int oz, output int od);
        int kw;
        md = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 8);
        ex = $urandom_range(0, md);
        ey = $urandom_range(0, md - ex);
        ez = $urandom_range(0, md - ex - ey);
        kw = md - ex - ey - ez;
        ox = $urandom_range(0, ex);
        oy = $urandom_range(0, ey);
        oz = $urandom_range(0, ez);
        od = ox + oy + oz + $urandom_range(0, kw);
    endtask

    // stimulus
    initial begin
        int          ex, ey, ez, md, ox, oy, oz, od, mode;
        logic [31:0] c;
        steady     = 1'b0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corner terms
        send_term(32'h0000_0000, 0, 0, 0, 0, 0, 0, 0, 0);      // nothing at all
        send_term(32'h7fff_ffff, 3, 2, 1, 9, 0, 0, 0, 0);      // identity, max coef
        send_term(32'h8000_0000, 1, 1, 1, 3, 0, 0, 0, 0);      // identity, min coef
        send_term(32'h0001_0000, 3, 0, 0, 3, 2, 0, 0, 2);      // d2/dx2 of x^3
        send_term(32'h0002_8000, 2, 1, 1, 10, 1, 0, 0, 4);     // w and x derivative
        send_term(32'h0001_0000, 3, 0, 0, 3, 0, 0, 0, 1);      // w exponent zero
        send_term(32'h0001_0000, 3, 0, 0, 5, 0, 0, 0, 3);      // w order above exponent
        send_term(32'h0001_0000, 5, 5, 5, 1, 2, 1, 1, 4);      // degree below exponent sum
        send_term(32'hffff_0000, 4, 0, 0, 4, 2, 0, 0, 0);      // negative w order
        send_term(32'h0001_0000, 2, 0, 0, 10, 3, 0, 0, 3);     // x order above exponent
        send_term(32'h0001_0000, 0, 2, 0, 10, 1, 0, 0, 1);     // x exponent zero
        send_term(32'h0001_0000, 2, 2, 0, 10, 1, 3, 0, 4);     // y order above exponent
        send_term(32'h0001_0000, 2, 2, 2, 10, 1, 1, 5, 7);     // z order above exponent
        send_term(32'h7fff_ffff, 31, 0, 0, 31, 31, 0, 0, 31);  // positive clip
        send_term(32'h8000_0000, 31, 0, 0, 31, 31, 0, 0, 31);  // negative clip
        send_term(32'hffff_ffff, 0, 0, 31, 31, 0, 0, 31, 31);  // -1 lsb, long z chain
        send_term(32'h0000_0001, 0, 0, 0, 31, 0, 0, 0, 31);    // long w chain
        send_term(32'h7fff_ffff, 31, 0, 0, 31, 10, 1, 0, 11);  // clip then killed
        send_term(32'h0000_0000, 5, 0, 0, 31, 2, 0, 0, 2);     // zero coef is not killed
        send_term(32'hffff_ffff, 31, 31, 31, 31, 31, 31, 31, 31); // every field max
        send_term(32'hffff_0000, 0, 4, 3, 9, 0, 2, 3, 6);      // negative, y z and w
        send_term(32'h0000_4000, 1, 1, 1, 31, 1, 1, 1, 31);    // w order 28 of 28
        wait_empty();

        // random terms
        for (int n = 0; n < N_RANDOM; n++) begin
            steady = ((n / 120) % 4) == 3;
            if (n == N_RANDOM / 2)
                wait_empty();
            mode = $urandom_range(0, 9);
            c    = pick_coef();
            if (mode <= 5) begin
                make_valid(ex, ey, ez, md, ox, oy, oz, od);
            end else if (mode <= 7) begin
                make_valid(ex, ey, ez, md, ox, oy, oz, od);
                case ($urandom_range(0, 3))
                    0: begin
                        ox = (ex + 1 + $urandom_range(0, 2)) & 31;
                        od = (od + ox) & 31;
                    end
                    1: begin
                        oy = (ey + 1 + $urandom_range(0, 2)) & 31;
                        od = (od + oy) & 31;
                    end
                    2: begin
                        oz = (ez + 1 + $urandom_range(0, 2)) & 31;
                        od = (od + oz) & 31;
                    end
                    default: od = (ox + oy + oz + md - ex - ey - ez + 1
                                   + $urandom_range(0, 3)) & 31;
                endcase
            end else begin
                ex = $urandom_range(0, 31);
                ey = $urandom_range(0, 31);
                ez = $urandom_range(0, 31);
                md = $urandom_range(0, 31);
                ox = $urandom_range(0, 31);
                oy = $urandom_range(0, 31);
                oz = $urandom_range(0, 31);
                od = $urandom_range(0, 31);
                c  = $urandom;
            end
            send_term(c, ex, ey, ez, md, ox, oy, oz, od);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        steady = 1'b0;

        // drain, then leave room for any stray result
        wait_empty();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d terms sent, %0d results checked", taken, checked);
        $display("%0d results were zero monomials, %0d had a clipped coefficient",
                 zero_count, sat_count);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
